// File: hdl/gif_lzw_pixel_decoder_top_macros.svh
// assertion macros for the lzw pixel decoder
`ifndef GIF_LZW_PIXEL_DECODER_TOP_MACROS_SVH
`define GIF_LZW_PIXEL_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error("gld check failed");
`define GLD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error("gld check failed");
`else
`define GLD_ASSERT_ALWAYS(lbl, expr)
`define GLD_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// File: hdl/gld_pkg.sv
`timescale 1ns / 1ps
package gld_pkg;
	localparam int BUF_W = 24;
	localparam int HELD_W = 5;
	localparam int CW_W = 4;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PUSH  = 2'd1,
		OP_END   = 2'd2,
		OP_REQ   = 2'd3
	} gld_op_t;

	typedef enum logic [2:0] {
		STS_PIXEL = 3'd0,
		STS_NEED  = 3'd1,
		STS_ENDC  = 3'd2,
		STS_OOD   = 3'd3,
		STS_CIRC  = 3'd4,
		STS_FULL  = 3'd5
	} gld_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_CODE,
		S_LOOK,
		S_FETCH
	} gld_state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} gld_item_t;

	// queue handshake between front and back
	typedef struct packed {
		logic      valid;
		gld_item_t item;
	} gld_queue_t;
endpackage

// File: hdl/gld_req_if.sv
`timescale 1ns / 1ps
interface gld_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

// File: hdl/gld_rsp_if.sv
`timescale 1ns / 1ps
interface gld_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_index;
	logic [2:0] status;
	modport source (output valid, output pixel_index, output status, input ready);
	modport sink (input valid, input pixel_index, input status, output ready);
endinterface

// File: hdl/gld_cfg_if.sv
`timescale 1ns / 1ps
interface gld_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] min_code_size;
	modport source (output valid, output min_code_size, input ready);
	modport sink (input valid, input min_code_size, output ready);
endinterface

// File: hdl/gld_ram.sv
`timescale 1ns / 1ps
module gld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/gld_front.sv
`timescale 1ns / 1ps
module gld_front (
	input  logic               clk,
	input  logic               arst_n,
	gld_req_if.sink            req,
	input  logic               pop,
	output gld_pkg::gld_queue_t q
);
	import gld_pkg::*;

	gld_item_t  mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       take;

	assign req.ready = (count_q != 2'd2);
	assign push = req.valid && req.ready;
	assign take = pop && (count_q != 2'd0);
	assign q.valid = (count_q != 2'd0);
	assign q.item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= '{operation: req.operation, data_byte: req.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (take) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(take);
		end
	end
endmodule

// File: hdl/gld_back.sv
`timescale 1ns / 1ps
module gld_back #(
	parameter int MAX_CODE_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          min_code_size,
	input  gld_pkg::gld_queue_t q,
	output logic                pop,
	gld_rsp_if.source           rsp
);
	import gld_pkg::*;

	localparam int AW = MAX_CODE_BITS;
	localparam int TBL = 1 << AW;
	localparam int SD = TBL + 1;
	localparam int FW = $clog2(SD);

	gld_state_t       state_q, state_n;
	logic [3:0]       size_q, size_n;
	logic [CW_W-1:0]  width_q, width_n;
	logic [AW:0]      nfc_q, nfc_n;
	logic [AW:0]      limit_q, limit_n;
	logic [7:0]       first_q, first_n;
	logic [AW-1:0]    prev_q, prev_n;
	logic [BUF_W-1:0] bbuf_q, bbuf_n;
	logic [HELD_W-1:0] held_q, held_n;
	logic             fresh_q, fresh_n;
	logic             ended_q, ended_n;
	logic             fin_q, fin_n;
	logic [FW-1:0]    fill_q, fill_n;
	logic [AW-1:0]    cur_q, cur_n;
	logic [AW-1:0]    code_q, code_n;
	logic             ovalid_q, ovalid_n;
	logic [7:0]       opix_q, opix_n;
	logic [2:0]       ost_q, ost_n;

	logic             tbl_wen;
	logic [AW-1:0]    tbl_waddr;
	logic [AW-1:0]    tbl_raddr;
	logic [AW-1:0]    pre_rdata;
	logic [7:0]       suf_rdata;
	logic             stk_wen;
	logic [FW-1:0]    stk_waddr;
	logic [7:0]       stk_wdata;
	logic [FW-1:0]    stk_raddr;
	logic [7:0]       stk_rdata;

	logic             slot_free;
	logic [AW:0]      clear_c;
	logic [AW:0]      endc_c;
	logic [3:0]       size_s;
	logic [AW:0]      clear_s;
	logic [BUF_W-1:0] mask_c;
	logic [AW:0]      code_c;

	gld_ram #(.WIDTH(AW), .DEPTH(TBL)) u_prefix (
		.clk(clk), .wen(tbl_wen), .waddr(tbl_waddr), .wdata(prev_q),
		.raddr(tbl_raddr), .rdata(pre_rdata)
	);
	gld_ram #(.WIDTH(8), .DEPTH(TBL)) u_suffix (
		.clk(clk), .wen(tbl_wen), .waddr(tbl_waddr), .wdata(cur_q[7:0]),
		.raddr(tbl_raddr), .rdata(suf_rdata)
	);
	gld_ram #(.WIDTH(8), .DEPTH(SD)) u_stack (
		.clk(clk), .wen(stk_wen), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign slot_free = !ovalid_q || rsp.ready;
	assign rsp.valid = ovalid_q;
	assign rsp.pixel_index = opix_q;
	assign rsp.status = ost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q <= 4'd8;
			width_q <= CW_W'(9);
			nfc_q <= (AW+1)'(258);
			limit_q <= (AW+1)'(512);
			first_q <= 8'd0;
			prev_q <= '0;
			bbuf_q <= '0;
			held_q <= '0;
			fresh_q <= 1'b1;
			ended_q <= 1'b0;
			fin_q <= 1'b0;
			fill_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			size_q <= size_n;
			width_q <= width_n;
			nfc_q <= nfc_n;
			limit_q <= limit_n;
			first_q <= first_n;
			prev_q <= prev_n;
			bbuf_q <= bbuf_n;
			held_q <= held_n;
			fresh_q <= fresh_n;
			ended_q <= ended_n;
			fin_q <= fin_n;
			fill_q <= fill_n;
			ovalid_q <= ovalid_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_n;
		code_q <= code_n;
		opix_q <= opix_n;
		ost_q <= ost_n;
	end

	always_comb begin
		clear_c = (AW+1)'(1) << size_q;
		endc_c = clear_c + (AW+1)'(1);
		size_s = min_code_size;
		if (size_s < 4'd2) begin
			size_s = 4'd2;
		end else if (size_s > 4'd8) begin
			size_s = 4'd8;
		end
		clear_s = (AW+1)'(1) << size_s;
		mask_c = (BUF_W'(1) << width_q) - BUF_W'(1);
		code_c = (AW+1)'(bbuf_q & mask_c);

		state_n = state_q;
		size_n = size_q;
		width_n = width_q;
		nfc_n = nfc_q;
		limit_n = limit_q;
		first_n = first_q;
		prev_n = prev_q;
		bbuf_n = bbuf_q;
		held_n = held_q;
		fresh_n = fresh_q;
		ended_n = ended_q;
		fin_n = fin_q;
		fill_n = fill_q;
		cur_n = cur_q;
		code_n = code_q;
		ovalid_n = ovalid_q && !rsp.ready;
		opix_n = opix_q;
		ost_n = ost_q;
		pop = 1'b0;
		tbl_wen = 1'b0;
		tbl_waddr = nfc_q[AW-1:0];
		tbl_raddr = cur_q;
		stk_wen = 1'b0;
		stk_waddr = fill_q;
		stk_wdata = 8'd0;
		stk_raddr = fill_q - FW'(1);

		case (state_q)
			S_IDLE: begin
				if (q.valid && slot_free) begin
					pop = 1'b1;
					ovalid_n = 1'b1;
					opix_n = 8'd0;
					ost_n = STS_PIXEL;
					case (gld_op_t'(q.item.operation))
						OP_START: begin
							size_n = size_s;
							width_n = CW_W'(size_s + 4'd1);
							nfc_n = clear_s + (AW+1)'(2);
							limit_n = clear_s << 1;
							fill_n = '0;
							fresh_n = 1'b1;
							bbuf_n = '0;
							held_n = '0;
							ended_n = 1'b0;
							fin_n = 1'b0;
						end
						OP_PUSH: begin
							if (held_q > HELD_W'(16)) begin
								ost_n = STS_FULL;
							end else begin
								bbuf_n = bbuf_q | (BUF_W'(q.item.data_byte) << held_q);
								held_n = held_q + HELD_W'(8);
							end
						end
						OP_END: begin
							ended_n = 1'b1;
						end
						default: begin
							if (fin_q) begin
								ost_n = STS_ENDC;
							end else if (fill_q != '0) begin
								ovalid_n = 1'b0;
								fill_n = fill_q - FW'(1);
								state_n = S_POP;
							end else begin
								ovalid_n = 1'b0;
								state_n = S_CODE;
							end
						end
					endcase
				end
			end
			S_POP: begin
				ovalid_n = 1'b1;
				opix_n = stk_rdata;
				ost_n = STS_PIXEL;
				state_n = S_IDLE;
			end
			S_CODE: begin
				if (held_q < HELD_W'(width_q)) begin
					ovalid_n = 1'b1;
					opix_n = 8'd0;
					ost_n = ended_q ? STS_OOD : STS_NEED;
					state_n = S_IDLE;
				end else begin
					bbuf_n = bbuf_q >> width_q;
					held_n = held_q - HELD_W'(width_q);
					opix_n = 8'd0;
					if (code_c == endc_c) begin
						fin_n = 1'b1;
						ovalid_n = 1'b1;
						ost_n = STS_ENDC;
						state_n = S_IDLE;
					end else if (fresh_q) begin
						if (code_c == clear_c) begin
							state_n = S_CODE;
						end else if (code_c > endc_c) begin
							ovalid_n = 1'b1;
							ost_n = STS_CIRC;
							state_n = S_IDLE;
						end else begin
							fresh_n = 1'b0;
							first_n = code_c[7:0];
							prev_n = code_c[AW-1:0];
							ovalid_n = 1'b1;
							opix_n = code_c[7:0];
							ost_n = STS_PIXEL;
							state_n = S_IDLE;
						end
					end else if (code_c == clear_c) begin
						// table rebuild, roots need no write
						width_n = CW_W'(size_q + 4'd1);
						nfc_n = clear_c + (AW+1)'(2);
						limit_n = clear_c << 1;
						fill_n = '0;
						fresh_n = 1'b1;
					end else if (code_c > nfc_q) begin
						ovalid_n = 1'b1;
						ost_n = STS_CIRC;
						state_n = S_IDLE;
					end else begin
						code_n = code_c[AW-1:0];
						if (code_c == nfc_q) begin
							// code not yet in the table
							stk_wen = 1'b1;
							stk_waddr = '0;
							stk_wdata = first_q;
							fill_n = FW'(1);
							cur_n = prev_q;
						end else begin
							fill_n = '0;
							cur_n = code_c[AW-1:0];
						end
						state_n = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				if ((AW+1)'(cur_q) < clear_c) begin
					// root reached: it is the pixel, the stack holds the rest
					first_n = cur_q[7:0];
					if (nfc_q < (AW+1)'(TBL)) begin
						tbl_wen = 1'b1;
						nfc_n = nfc_q + (AW+1)'(1);
						if ((nfc_q + (AW+1)'(1) >= limit_q) && (limit_q < (AW+1)'(TBL))) begin
							limit_n = limit_q << 1;
							width_n = width_q + CW_W'(1);
						end
					end
					prev_n = code_q;
					ovalid_n = 1'b1;
					opix_n = cur_q[7:0];
					ost_n = STS_PIXEL;
					state_n = S_IDLE;
				end else if (fill_q >= FW'(TBL)) begin
					fill_n = '0;
					ovalid_n = 1'b1;
					opix_n = 8'd0;
					ost_n = STS_CIRC;
					state_n = S_IDLE;
				end else if (((AW+1)'(cur_q) == clear_c) || ((AW+1)'(cur_q) == endc_c)) begin
					// clear and end entries are not read: they count as suffix and prefix zero
					stk_wen = 1'b1;
					stk_wdata = 8'd0;
					fill_n = fill_q + FW'(1);
					cur_n = '0;
				end else begin
					state_n = S_FETCH;
				end
			end
			S_FETCH: begin
				if (pre_rdata == cur_q) begin
					fill_n = '0;
					ovalid_n = 1'b1;
					opix_n = 8'd0;
					ost_n = STS_CIRC;
					state_n = S_IDLE;
				end else begin
					stk_wen = 1'b1;
					stk_wdata = suf_rdata;
					fill_n = fill_q + FW'(1);
					cur_n = pre_rdata;
					state_n = S_LOOK;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end
endmodule

// File: hdl/gif_lzw_pixel_decoder_top.sv
`timescale 1ns / 1ps
// channel | dir | handshake     | payload
// req     | in  | valid / ready | operation, data_byte
// rsp     | out | valid / ready | pixel_index, status
// cfg     | in  | valid / ready | min_code_size
//
// start, push and end of data are handled in the idle state; a pixel from the stack goes through S_POP
// every code is taken in S_CODE; a code that is not the first after start or clear then walks the table
//   through S_LOOK and S_FETCH (one registered prefix/suffix read per entry); each clear code repeats S_CODE
// reset is asynchronous and gives the state of a start with code size 8; no clearing pass
// the 2-item queue takes items while the back end works or the result register waits
module gif_lzw_pixel_decoder_top #(
	parameter int MAX_CODE_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	gld_req_if.sink   req,
	gld_rsp_if.source rsp,
	gld_cfg_if.sink   cfg
);
	import gld_pkg::*;
	`include "gif_lzw_pixel_decoder_top_macros.svh"

	// latched config, applied at the next start item
	logic [3:0] mcs_q;
	gld_queue_t q;
	logic       q_valid;
	logic       q_pop;

	assign cfg.ready = 1'b1;
	assign q_valid = q.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcs_q <= 4'd8;
		end else if (cfg.valid) begin
			mcs_q <= cfg.min_code_size;
		end
	end

	// front: accepts and queues items
	gld_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.pop(q_pop),
		.q(q)
	);

	// back: decoder sequencer with table and stack memories
	gld_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.min_code_size(mcs_q),
		.q(q),
		.pop(q_pop),
		.rsp(rsp)
	);

	// non-pixel results carry a zero index
	`GLD_ASSERT_IMPLY(a_nonpixel_zero, rsp.valid && (rsp.status != STS_PIXEL), rsp.pixel_index == 8'd0)
	// a full queue means items are waiting
	`GLD_ASSERT_IMPLY(a_full_queue, !req.ready, q_valid)
	// back end only takes an item that is there
	`GLD_ASSERT_IMPLY(a_pop_valid, q_pop, q_valid)
endmodule

// File: bench/gld_pixel_checker.sv
`timescale 1ns / 1ps
module gld_pixel_checker (
	input  logic clk,
	input  logic arst_n,
	gld_req_if   req,
	gld_rsp_if   rsp,
	gld_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import gld_pkg::*;

	localparam int TBL = 4096;

	typedef struct {
		logic [7:0]  pix;
		gld_status_t st;
	} pixel_result_t;

	pixel_result_t expected_pixels[$];

	logic [3:0]  size_reg;
	int unsigned act_size;
	logic [11:0] prefix_mem[TBL];
	logic [7:0]  suffix_mem[TBL];
	logic [7:0]  char_stk[TBL + 1];
	int unsigned fill;
	int unsigned code_w;
	int unsigned free_code;
	int unsigned grow_at;
	logic [7:0]  lead_char;
	logic [11:0] last_code;
	int unsigned bitbuf;
	int unsigned nbits;
	bit          fresh;
	bit          data_done;
	bit          ended;

	function automatic void rebuild_table();
		int unsigned clr;
		clr = 1 << act_size;
		for (int i = 0; i < TBL; i++) begin
			prefix_mem[i] = '0;
			suffix_mem[i] = (i < clr) ? i[7:0] : 8'd0;
		end
		code_w = act_size + 1;
		free_code = clr + 2;
		grow_at = 2 * clr;
		fill = 0;
		fresh = 1;
	endfunction

	function automatic void begin_image();
		int unsigned s;
		s = size_reg;
		if (s < 2) s = 2;
		if (s > 8) s = 8;
		act_size = s;
		rebuild_table();
		bitbuf = 0;
		nbits = 0;
		data_done = 0;
		ended = 0;
	endfunction

	function automatic gld_status_t pull_code(output int unsigned code);
		code = 0;
		if (nbits < code_w) return data_done ? STS_OOD : STS_NEED;
		code = bitbuf & ((1 << code_w) - 1);
		bitbuf = bitbuf >> code_w;
		nbits = nbits - code_w;
		return STS_PIXEL;
	endfunction

	function automatic gld_status_t decode_pixel(output logic [7:0] pix);
		int unsigned clr, endc, code, cur;
		gld_status_t st;
		clr = 1 << act_size;
		endc = clr + 1;
		pix = 8'd0;
		if (ended) return STS_ENDC;
		if (fill > 0) begin
			fill--;
			pix = char_stk[fill];
			return STS_PIXEL;
		end
		while (1) begin
			st = pull_code(code);
			if (st != STS_PIXEL) return st;
			if (code == endc) begin
				ended = 1;
				return STS_ENDC;
			end
			if (fresh) begin
				// clears right after a clear are skipped
				if (code == clr) continue;
				if (code > endc) return STS_CIRC;
				fresh = 0;
				lead_char = code[7:0];
				last_code = code[11:0];
				pix = code[7:0];
				return STS_PIXEL;
			end
			if (code == clr) begin
				rebuild_table();
				continue;
			end
			if (code > free_code) return STS_CIRC;
			fill = 0;
			cur = code;
			// code not yet in the table: previous string plus its first char
			if (code == free_code) begin
				char_stk[fill] = lead_char;
				fill++;
				cur = last_code;
			end
			cur = cur & (TBL - 1);
			while (cur >= clr) begin
				if (fill >= TBL || prefix_mem[cur] == cur) begin
					fill = 0;
					return STS_CIRC;
				end
				char_stk[fill] = suffix_mem[cur];
				fill++;
				cur = prefix_mem[cur];
			end
			lead_char = suffix_mem[cur];
			char_stk[fill] = lead_char;
			fill++;
			if (free_code < TBL) begin
				prefix_mem[free_code] = last_code;
				suffix_mem[free_code] = lead_char;
				free_code++;
				if (free_code >= grow_at && grow_at < TBL) begin
					grow_at = grow_at * 2;
					code_w++;
				end
			end
			last_code = code[11:0];
			fill--;
			pix = char_stk[fill];
			return STS_PIXEL;
		end
		return STS_PIXEL;
	endfunction

	function automatic pixel_result_t predict(logic [1:0] op, logic [7:0] b);
		pixel_result_t r;
		logic [7:0] p;
		r.pix = 8'd0;
		r.st = STS_PIXEL;
		case (op)
			OP_START: begin
				begin_image();
			end
			OP_PUSH: begin
				if (nbits > 16) r.st = STS_FULL;
				else begin
					bitbuf = (bitbuf | (int'(b) << nbits)) & 32'hFFFFFF;
					nbits += 8;
				end
			end
			OP_END: begin
				data_done = 1;
			end
			default: begin
				r.st = decode_pixel(p);
				if (r.st == STS_PIXEL) r.pix = p;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t e, r;
		int errs;
		errs = 0;
		if (!arst_n) begin
			size_reg = 4'd8;
			for (int i = 0; i <= TBL; i++) char_stk[i] = 8'd0;
			lead_char = 8'd0;
			last_code = 12'd0;
			begin_image();
			expected_pixels.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("result with none expected: pixel_index %0d status %0d",
						rsp.pixel_index, rsp.status);
					errs++;
				end else begin
					e = expected_pixels.pop_front();
					if (rsp.pixel_index !== e.pix) begin
						$error("pixel_index expected %0d actual %0d", e.pix, rsp.pixel_index);
						errs++;
					end
					if (rsp.status !== e.st) begin
						$error("status expected %0d actual %0d", e.st, rsp.status);
						errs++;
					end
				end
			end
			if (cfg.valid && cfg.ready) size_reg = cfg.min_code_size;
			if (req.valid && req.ready) begin
				r = predict(req.operation, req.data_byte);
				expected_pixels.push_back(r);
			end
			if (errs != 0) fail_count <= fail_count + errs;
			pending <= expected_pixels.size();
		end
	end
endmodule

// File: bench/gif_lzw_pixel_decoder_top_test.sv
`timescale 1ns / 1ps
module gif_lzw_pixel_decoder_top_test;
	import gld_pkg::*;

	logic clk;
	logic arst_n;

	gld_req_if req ();
	gld_rsp_if rsp ();
	gld_cfg_if cfg ();

	int fail_count;
	int pending;

	gif_lzw_pixel_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// watches all three channels and predicts every result
	gld_pixel_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// handshake bookkeeping for flow control of the stimulus
	int req_cnt, rsp_cnt, pixel_cnt, need_cnt, endc_cnt, ood_cnt, idle_cycles;
	int images, noise_items;
	bit send_idle_on, recv_stall_on, hold_flag;
	// last size written to the config register
	logic [3:0] size_written;

	always @(posedge clk) begin
		if (!arst_n) begin
			req_cnt <= 0;
			rsp_cnt <= 0;
			pixel_cnt <= 0;
			need_cnt <= 0;
			endc_cnt <= 0;
			ood_cnt <= 0;
		end else begin
			if (req.valid && req.ready) req_cnt <= req_cnt + 1;
			if (rsp.valid && rsp.ready) begin
				rsp_cnt <= rsp_cnt + 1;
				case (rsp.status)
					STS_PIXEL: pixel_cnt <= pixel_cnt + 1;
					STS_NEED:  need_cnt <= need_cnt + 1;
					STS_ENDC:  endc_cnt <= endc_cnt + 1;
					STS_OOD:   ood_cnt <= ood_cnt + 1;
					default: ;
				endcase
			end
		end
	end

	// watchdog: too long without any item moving on any channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 50000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stall per item, plus one long hold-off on request
	initial begin
		int n;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_flag) begin
				hold_flag = 0;
				rsp.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				n = recv_stall_on ? $urandom_range(0, 9) : 0;
				if (n > 0) begin
					rsp.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// offer one item; valid stays high when the next one follows without a gap
	task automatic send_item(input gld_op_t op, input logic [7:0] b);
		int gap;
		gap = send_idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.data_byte <= b;
		do @(posedge clk); while (!req.ready);
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (rsp_cnt != req_cnt);
	endtask

	task automatic write_size(input logic [3:0] v);
		cfg.valid <= 1'b1;
		cfg.min_code_size <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		size_written = v;
	endtask

	// lzw encoder state, mirrors the width rule of the decoder
	logic [7:0]  stream_q[$];
	int unsigned acc, nb;
	int          enc_w, dec_next, dec_limit, ncode;

	task automatic pack_code(input int code, input int width);
		acc = acc | (code << nb);
		nb += width;
		while (nb >= 8) begin
			stream_q.push_back(acc[7:0]);
			acc = acc >> 8;
			nb -= 8;
		end
	endtask

	task automatic emit_code(input int code);
		pack_code(code, enc_w);
		// the decoder adds an entry for every code but the first after a clear
		if (ncode >= 1 && dec_next < 4096) begin
			dec_next++;
			if (dec_next >= dec_limit && dec_limit < 4096) begin
				dec_limit *= 2;
				enc_w++;
			end
		end
		ncode++;
	endtask

	task automatic build_image(input int sz, input int npix, input int alpha);
		int dict[int];
		int clr, enc_next, w, c, key;
		clr = 1 << sz;
		stream_q.delete();
		acc = 0;
		nb = 0;
		enc_w = sz + 1;
		dec_next = clr + 2;
		dec_limit = 2 * clr;
		ncode = 0;
		enc_next = clr + 2;
		pack_code(clr, enc_w);
		w = $urandom_range(0, alpha - 1);
		for (int i = 1; i < npix; i++) begin
			c = $urandom_range(0, alpha - 1);
			key = w * 256 + c;
			if (dict.exists(key)) w = dict[key];
			else begin
				emit_code(w);
				// now and then a clear in the middle of the data
				if ($urandom_range(0, 39) == 0) begin
					pack_code(clr, enc_w);
					dict.delete();
					enc_next = clr + 2;
					enc_w = sz + 1;
					dec_next = clr + 2;
					dec_limit = 2 * clr;
					ncode = 0;
				end else if (enc_next < 4095) begin
					dict[key] = enc_next;
					enc_next++;
				end
				w = c;
			end
		end
		emit_code(w);
		pack_code(clr + 1, enc_w);
		if (nb > 0) stream_q.push_back(acc[7:0]);
	endtask

	// feed the stream as the decoder asks for it: bursts of requests,
	// a byte whenever a burst came back short of bits
	task automatic play_stream();
		int burst, need0, end0, ood0;
		for (int guard = 0; guard < 4000; guard++) begin
			need0 = need_cnt;
			end0 = endc_cnt;
			ood0 = ood_cnt;
			burst = $urandom_range(1, 6);
			repeat (burst) send_item(OP_REQ, 8'd0);
			drain();
			if (endc_cnt != end0 || ood_cnt != ood0) break;
			if (need_cnt != need0) begin
				if (stream_q.size() > 0) send_item(OP_PUSH, stream_q.pop_front());
				else send_item(OP_END, 8'd0);
			end
		end
		drain();
	endtask

	task automatic noise(input int n);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: send_item(OP_START, 8'($urandom_range(0, 255)));
				1: send_item(OP_END, 8'($urandom_range(0, 255)));
				2, 3, 4, 5: send_item(OP_PUSH, 8'($urandom_range(0, 255)));
				default: send_item(OP_REQ, 8'($urandom_range(0, 255)));
			endcase
			noise_items++;
		end
	endtask

	initial begin
		int sz, npix, alpha, phase;
		int dir_codes[8] = '{256, 256, 300, 65, 500, 258, 66, 257};
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.operation <= OP_START;
		req.data_byte <= 8'd0;
		cfg.valid <= 1'b0;
		cfg.min_code_size <= 4'd8;
		size_written = 4'd8;
		send_idle_on = 1;
		recv_stall_on = 1;
		hold_flag = 0;
		images = 0;
		noise_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: request with no data, out of data, buffer full
		send_item(OP_REQ, 8'd0);
		send_item(OP_END, 8'd0);
		send_item(OP_REQ, 8'd0);
		send_item(OP_START, 8'd0);
		send_item(OP_PUSH, 8'hFF);
		send_item(OP_PUSH, 8'h00);
		send_item(OP_PUSH, 8'hFF);
		send_item(OP_PUSH, 8'h00);
		send_item(OP_START, 8'd0);
		drain();

		// repeated clears, bad first code, code past the table, kwkwk, end code
		stream_q.delete();
		acc = 0;
		nb = 0;
		foreach (dir_codes[i]) pack_code(dir_codes[i], 9);
		if (nb > 0) stream_q.push_back(acc[7:0]);
		play_stream();
		// end code is sticky, pushes are still taken
		send_item(OP_REQ, 8'd0);
		send_item(OP_PUSH, 8'hA5);
		send_item(OP_START, 8'd0);
		drain();

		phase = 0;
		while (req_cnt < 1950) begin
			drain();
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_stall_on = ($urandom_range(0, 3) != 0);
			// size setting: extremes and out-of-range values first, then random
			case (phase)
				0: write_size(4'd2);
				1: write_size(4'd8);
				2: write_size(4'd0);
				3: write_size(4'd15);
				default: if ($urandom_range(0, 1) == 0) write_size(4'($urandom_range(0, 15)));
			endcase
			sz = size_written;
			if (sz < 2) sz = 2;
			if (sz > 8) sz = 8;
			if (phase == 4) begin
				// long hold-off on results while items keep coming
				send_idle_on = 0;
				hold_flag = 1;
				noise(40);
			end else if (phase % 5 == 3) begin
				noise(30);
			end else begin
				if (phase % 7 == 5) begin
					sz = 2;
					npix = 400;
					alpha = 2;
				end else begin
					npix = $urandom_range(2, 80);
					alpha = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : (1 << sz);
				end
				// image must start from the latched size
				send_item(OP_START, 8'd0);
				build_image(sz, npix, alpha);
				// some streams are cut short
				if ($urandom_range(0, 7) == 0)
					stream_q = stream_q[0:$urandom_range(0, stream_q.size() - 1)];
				play_stream();
				images++;
			end
			phase++;
		end
		drain();
		repeat (50) @(posedge clk);

		$display("run: %0d items, %0d images, %0d noise items, %0d pixels", req_cnt, images,
			noise_items, pixel_cnt);
		$display("statuses: %0d need data, %0d end code, %0d out of data", need_cnt, endc_cnt,
			ood_cnt);
		if (pending != 0) $error("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
